[rtl/lse_pkg.sv]
// ----------------------------------------------------------------------------
// LSB stego extractor package
// Shared widths, register indexes, section codes and beat structs.
// ----------------------------------------------------------------------------
package lse_pkg;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int SECTION_W   = 2;
    localparam int SKIP_W      = 16;
    localparam int MAGIC_W     = 64;
    localparam int MAGIC_LEN_W = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int WORD_W      = 32;
    localparam int BITCNT_W    = 5;

    // magic string holds at most this many bytes
    localparam logic [MAGIC_LEN_W-1:0] MAX_MAGIC_BYTES = 4'd8;

    // reset values of the registers
    localparam logic [SKIP_W-1:0]      HEADER_SKIP_RST  = 16'd54;
    localparam logic [MAGIC_W-1:0]     MAGIC_VALUE_RST  = 64'd0;
    localparam logic [MAGIC_LEN_W-1:0] MAGIC_LENGTH_RST = 4'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SKIP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_VALUE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_LENGTH = 2'd2;

    // section codes
    localparam logic [SECTION_W-1:0] SEC_EXT   = 2'd0;
    localparam logic [SECTION_W-1:0] SEC_PAY   = 2'd1;
    localparam logic [SECTION_W-1:0] SEC_ERROR = 2'd2;

    typedef struct packed {
        logic [SKIP_W-1:0]      header_skip;
        logic [MAGIC_W-1:0]     magic_value;
        logic [MAGIC_LEN_W-1:0] magic_length;
    } lse_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    out_byte;
        logic [SECTION_W-1:0] section;
        logic                 section_last;
    } lse_result_t;

endpackage

[rtl/lse_image_if.sv]
// ----------------------------------------------------------------------------
// Image byte channel
// Valid/ready channel that carries one file byte and a start-of-file flag.
// ----------------------------------------------------------------------------
interface lse_image_if
    import lse_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] image_byte;
    logic              frame_start;

    modport source (output valid, output image_byte, output frame_start, input ready);
    modport sink   (input valid, input image_byte, input frame_start, output ready);
endinterface

[rtl/lse_hidden_if.sv]
// ----------------------------------------------------------------------------
// Hidden byte channel
// Valid/ready channel that carries one recovered byte with its section tags.
// ----------------------------------------------------------------------------
interface lse_hidden_if
    import lse_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    out_byte;
    logic [SECTION_W-1:0] section;
    logic                 section_last;

    modport source (output valid, output out_byte, output section, output section_last,
                    input ready);
    modport sink   (input valid, input out_byte, input section, input section_last,
                    output ready);
endinterface

[rtl/lse_parser.sv]
// ----------------------------------------------------------------------------
// LSB stego parser
// Per-beat parse state: header skip, LSB gathering, magic check, length
// words and section byte emission. State advances on each accepted beat.
// ----------------------------------------------------------------------------
module lse_parser
    import lse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] image_byte,
    input  logic              frame_start,
    input  lse_cfg_t          cfg,
    output logic              emit,
    output lse_result_t       result
);

    localparam logic [2:0] PH_SKIP    = 3'd0;
    localparam logic [2:0] PH_MAGIC   = 3'd1;
    localparam logic [2:0] PH_EXT_LEN = 3'd2;
    localparam logic [2:0] PH_EXT     = 3'd3;
    localparam logic [2:0] PH_PAY_LEN = 3'd4;
    localparam logic [2:0] PH_PAY     = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam logic [BITCNT_W-1:0] BYTE_LAST_BIT = 5'd7;
    localparam logic [BITCNT_W-1:0] WORD_LAST_BIT = 5'd31;

    logic [2:0]          phase_reg, phase_next;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [WORD_W-1:0]   shift_reg, shift_next;
    logic [WORD_W-1:0]   sec_cnt_reg, sec_cnt_next;
    logic [WORD_W-1:0]   sec_len_reg, sec_len_next;
    logic                magic_bad_reg, magic_bad_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            sec_cnt_reg   <= '0;
            sec_len_reg   <= '0;
            magic_bad_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            sec_cnt_reg   <= sec_cnt_next;
            sec_len_reg   <= sec_len_next;
            magic_bad_reg <= magic_bad_next;
        end
    end

    // one beat of parsing
    always_comb
    begin
        logic [2:0]             ph;
        logic [BITCNT_W-1:0]    bc;
        logic [WORD_W-1:0]      sh;
        logic [WORD_W-1:0]      cnt;
        logic [WORD_W-1:0]      cnt_inc;
        logic [WORD_W-1:0]      len;
        logic                   bad;
        logic                   unit_done;
        logic [BITCNT_W-1:0]    last_bit;
        logic [MAGIC_LEN_W-1:0] n_magic;
        logic [2:0]             byte_sel;
        logic [BYTE_W-1:0]      expect_byte;
        logic                   is_last;

        // restart on a new file
        ph  = frame_start ? PH_SKIP : phase_reg;
        bc  = frame_start ? '0 : bit_cnt_reg;
        sh  = frame_start ? '0 : shift_reg;
        cnt = frame_start ? '0 : sec_cnt_reg;
        len = frame_start ? '0 : sec_len_reg;
        bad = frame_start ? 1'b0 : magic_bad_reg;

        emit   = 1'b0;
        result = '0;

        // header skip; the first data beat falls through to the magic
        if (ph == PH_SKIP)
        begin
            if (cnt < {{(WORD_W-SKIP_W){1'b0}}, cfg.header_skip})
            begin
                cnt = cnt + 32'd1;
            end
            else
            begin
                ph  = PH_MAGIC;
                cnt = '0;
                bc  = '0;
                sh  = '0;
            end
        end

        // LSB gather, MSB first
        last_bit  = (ph == PH_EXT_LEN || ph == PH_PAY_LEN) ? WORD_LAST_BIT : BYTE_LAST_BIT;
        unit_done = 1'b0;
        if (ph != PH_SKIP && ph != PH_DONE)
        begin
            sh        = {sh[WORD_W-2:0], image_byte[0]};
            unit_done = (bc >= last_bit);
            bc        = unit_done ? '0 : bc + 5'd1;
        end

        // magic byte selection, count clamped to 1..MAX_MAGIC_BYTES
        if (cfg.magic_length == '0)
            n_magic = 4'd1;
        else if (cfg.magic_length > MAX_MAGIC_BYTES)
            n_magic = MAX_MAGIC_BYTES;
        else
            n_magic = cfg.magic_length;
        byte_sel    = 3'(n_magic - 4'd1 - {1'b0, cnt[2:0]});
        expect_byte = cfg.magic_value[{byte_sel, 3'b000} +: BYTE_W];

        cnt_inc = cnt + 32'd1;
        is_last = (cnt_inc >= len);

        if (unit_done)
        begin
            unique case (ph)
                PH_MAGIC:
                begin
                    if (sh[BYTE_W-1:0] != expect_byte)
                        bad = 1'b1;
                    cnt = cnt_inc;
                    if (cnt_inc >= {{(WORD_W-MAGIC_LEN_W){1'b0}}, n_magic})
                    begin
                        cnt = '0;
                        if (bad)
                        begin
                            ph                  = PH_DONE;
                            emit                = 1'b1;
                            result.out_byte     = '0;
                            result.section      = SEC_ERROR;
                            result.section_last = 1'b0;
                        end
                        else
                        begin
                            ph = PH_EXT_LEN;
                        end
                    end
                end
                PH_EXT_LEN:
                begin
                    len = sh;
                    cnt = '0;
                    ph  = (sh == '0) ? PH_PAY_LEN : PH_EXT;
                end
                PH_PAY_LEN:
                begin
                    len = sh;
                    cnt = '0;
                    ph  = (sh == '0) ? PH_DONE : PH_PAY;
                end
                PH_EXT, PH_PAY:
                begin
                    emit                = 1'b1;
                    result.out_byte     = sh[BYTE_W-1:0];
                    result.section      = (ph == PH_EXT) ? SEC_EXT : SEC_PAY;
                    result.section_last = is_last;
                    cnt                 = is_last ? '0 : cnt_inc;
                    if (is_last)
                        ph = (ph == PH_EXT) ? PH_PAY_LEN : PH_DONE;
                end
                default:
                begin
                end
            endcase
        end

        phase_next     = ph;
        bit_cnt_next   = bc;
        shift_next     = sh;
        sec_cnt_next   = cnt;
        sec_len_next   = len;
        magic_bad_next = bad;
    end

endmodule

[rtl/lsb_stego_extractor.sv]
// ----------------------------------------------------------------------------
// LSB stego extractor
// Recovers magic-checked extension and payload bytes hidden in image LSBs.
// ----------------------------------------------------------------------------
// Usage:
//   image  : one file byte per beat; frame_start marks byte 0 of a file and
//            restarts the parser. Only bit 0 of bytes past the header counts.
//   hidden : one recovered byte per beat, tagged extension / payload with a
//            last flag on the final byte of a section, or a single error beat
//            when the magic string does not match.
//   cfg    : header_skip, magic_value, magic_length; write only while idle.
// Timing:
//   One image beat is taken every cycle unless a result is held and not taken. A result shows on hidden the cycle
//   after the image beat that completes it (one output register). Eight image
//   beats make one hidden byte, so results are sparse.
// Reset:
//   Registers return to 54 / 0 / 2 and the parser waits in header skip; a
//   stream with no frame_start is parsed as a file starting at its first beat.
// Stall:
//   A result held by a stalled receiver stays on hidden; image.ready drops
//   only while a result is held and not taken in that cycle.
// ----------------------------------------------------------------------------
module lsb_stego_extractor
    import lse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lse_image_if.sink             image,
    lse_hidden_if.source          hidden
);

    lse_cfg_t    cfg_reg;
    logic        out_vld_reg, out_vld_next;
    lse_result_t res_reg, res_next;
    logic        accept;
    logic        emit;
    lse_result_t result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_skip  <= HEADER_SKIP_RST;
            cfg_reg.magic_value  <= MAGIC_VALUE_RST;
            cfg_reg.magic_length <= MAGIC_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER_SKIP:  cfg_reg.header_skip  <= cfg_data[SKIP_W-1:0];
                REG_MAGIC_VALUE:  cfg_reg.magic_value  <= cfg_data[MAGIC_W-1:0];
                REG_MAGIC_LENGTH: cfg_reg.magic_length <= cfg_data[MAGIC_LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input handshake
    assign image.ready = !out_vld_reg || hidden.ready;
    assign accept      = image.valid && image.ready;

    lse_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .image_byte  (image.image_byte),
        .frame_start (image.frame_start),
        .cfg         (cfg_reg),
        .emit        (emit),
        .result      (result)
    );

    // output register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        res_next     = res_reg;
        if (accept)
        begin
            out_vld_next = emit;
            if (emit)
                res_next = result;
        end
        else if (hidden.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign hidden.valid        = out_vld_reg;
    assign hidden.out_byte     = res_reg.out_byte;
    assign hidden.section      = res_reg.section;
    assign hidden.section_last = res_reg.section_last;

    // checks
    a_error_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
        hidden.valid && hidden.section == SEC_ERROR
        |-> hidden.out_byte == '0 && !hidden.section_last)
        else $error("error beat carries data");

    a_no_take_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        hidden.valid && !hidden.ready |-> !image.ready)
        else $error("image beat taken while result held");

    a_result_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hidden.valid) |-> $past(image.valid && image.ready))
        else $error("result appeared without an image beat");

    a_section_code: assert property (@(posedge clk) disable iff (!rst_n)
        hidden.valid |-> hidden.section == SEC_EXT || hidden.section == SEC_PAY
                         || hidden.section == SEC_ERROR)
        else $error("bad section code");

endmodule

[test/lsb_stego_extractor_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LSB stego extractor testbench
// Builds stego image files with hidden magic, extension and payload data in
// the byte LSBs and streams them into the extractor with random idling on
// both channels. A directed case table runs first, then random files, mangled
// files and noise. A beat-level predictor works out every hidden beat, and
// each beat taken from the block is checked against it field by field.
// ----------------------------------------------------------------------------
module lsb_stego_extractor_test;
    import lse_pkg::*;

    localparam int RAND_BEATS = 550;
    localparam int QUIET_BEATS = 200;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic [2:0] {
        PH_SKIP, PH_MAGIC, PH_EXT_LEN, PH_EXT, PH_PAY_LEN, PH_PAY, PH_DONE
    } parse_phase_t;

    // one row of the directed table: a whole file and the registers it runs with
    typedef struct {
        bit                     load;
        logic [SKIP_W-1:0]      skip;
        logic [MAGIC_W-1:0]     magic;
        logic [MAGIC_LEN_W-1:0] mlen;
        bit                     bad;
        logic [WORD_W-1:0]      ext_len;
        logic [WORD_W-1:0]      pay_len;
        int unsigned            cut;
        int unsigned            tail;
        int unsigned            split;
        logic [SKIP_W-1:0]      new_skip;
        bit                     lead_fs;
    } file_case_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lse_image_if  image ();
    lse_hidden_if hidden ();

    lsb_stego_extractor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .image     (image),
        .hidden    (hidden)
    );

    // predictor state and register copies
    parse_phase_t           ph;
    logic [BITCNT_W-1:0]    bit_cnt;
    logic [WORD_W-1:0]      shift_word;
    logic [WORD_W-1:0]      byte_cnt;
    logic [WORD_W-1:0]      sect_len;
    logic                   magic_miss;
    logic [SKIP_W-1:0]      skip_len;
    logic [MAGIC_W-1:0]     magic_word;
    logic [MAGIC_LEN_W-1:0] magic_len;

    lse_result_t hidden_due[$];
    lse_result_t want_r;
    logic [BYTE_W-1:0] img_q[$];
    file_case_t file_plan[$];

    bit typed_error = 0;
    bit src_idle = 1;
    bit sink_stall = 1;
    bit quiet = 0;
    int failures = 0;
    int beats_sent = 0;
    int hidden_seen = 0;
    int reg_writes = 0;
    int file_no = 0;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void restart_parse();
        ph = PH_SKIP;
        bit_cnt = '0;
        shift_word = '0;
        byte_cnt = '0;
        sect_len = '0;
        magic_miss = 1'b0;
    endfunction

    // 0 reads as 1, anything past the maximum reads as the maximum
    function automatic int unsigned magic_bytes(input logic [MAGIC_LEN_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_MAGIC_BYTES)
            return MAX_MAGIC_BYTES;
        return len;
    endfunction

    // shift one LSB in, MSB first; 1 when a unit of nbits is complete
    function automatic bit shift_in(input logic lsb, input int unsigned nbits);
        shift_word = {shift_word[WORD_W-2:0], lsb};
        if (bit_cnt >= nbits - 1) begin
            bit_cnt = '0;
            return 1'b1;
        end
        bit_cnt = bit_cnt + 1'b1;
        return 1'b0;
    endfunction

    function automatic bit decode_beat(input logic [BYTE_W-1:0] b, input logic fs,
                                       output lse_result_t r);
        int unsigned n;
        int unsigned sh;
        logic [BYTE_W-1:0] want;
        r = '0;
        if (fs)
            restart_parse();
        if (ph == PH_SKIP) begin
            if (byte_cnt < skip_len) begin
                byte_cnt = byte_cnt + 1;
                return 1'b0;
            end
            ph = PH_MAGIC;
            byte_cnt = '0;
            bit_cnt = '0;
            shift_word = '0;
        end
        case (ph)
            PH_MAGIC: begin
                n = magic_bytes(magic_len);
                if (!shift_in(b[0], 8))
                    return 1'b0;
                sh = 8 * ((n - 1 - (byte_cnt & 7)) & 7);
                want = magic_word[sh +: 8];
                if (shift_word[7:0] != want)
                    magic_miss = 1'b1;
                byte_cnt = byte_cnt + 1;
                if (byte_cnt >= n) begin
                    byte_cnt = '0;
                    if (magic_miss) begin
                        ph = PH_DONE;
                        r.out_byte = 8'h00;
                        r.section = SEC_ERROR;
                        r.section_last = 1'b0;
                        return 1'b1;
                    end
                    ph = PH_EXT_LEN;
                end
                return 1'b0;
            end
            PH_EXT_LEN, PH_PAY_LEN: begin
                if (!shift_in(b[0], 32))
                    return 1'b0;
                sect_len = shift_word;
                byte_cnt = '0;
                if (ph == PH_EXT_LEN)
                    ph = (sect_len == 0) ? PH_PAY_LEN : PH_EXT;
                else
                    ph = (sect_len == 0) ? PH_DONE : PH_PAY;
                return 1'b0;
            end
            PH_EXT, PH_PAY: begin
                if (!shift_in(b[0], 8))
                    return 1'b0;
                byte_cnt = byte_cnt + 1;
                r.out_byte = shift_word[7:0];
                r.section = (ph == PH_EXT) ? SEC_EXT : SEC_PAY;
                r.section_last = (byte_cnt >= sect_len);
                if (r.section_last) begin
                    byte_cnt = '0;
                    ph = (ph == PH_EXT) ? PH_PAY_LEN : PH_DONE;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // file builder: hides bits in the LSB of random cover bytes
    // ------------------------------------------------------------------------
    function automatic void hide(input logic [WORD_W-1:0] val, input int nbits);
        logic [BYTE_W-1:0] cover_b;
        for (int i = nbits - 1; i >= 0; i--) begin
            cover_b = 8'($urandom);
            cover_b[0] = val[i];
            img_q.push_back(cover_b);
        end
    endfunction

    function automatic void build_file(input int unsigned hdr, input int unsigned n,
                                       input logic [MAGIC_W-1:0] mval, input bit corrupt,
                                       input logic [WORD_W-1:0] ext_len,
                                       input logic [WORD_W-1:0] pay_len,
                                       input int unsigned cut, input int unsigned tail);
        int k;
        int unsigned cap;
        logic [BYTE_W-1:0] mb;
        img_q.delete();
        cap = (cut == 0) ? 32'hFFFF_FFFF : cut;
        repeat (hdr) img_q.push_back(8'($urandom));
        k = corrupt ? int'($urandom_range(0, n - 1)) : -1;
        for (int i = 0; i < n; i++) begin
            mb = mval[8 * (n - 1 - i) +: 8];
            if (i == k)
                mb = mb ^ 8'(1 << $urandom_range(0, 7));
            hide(mb, 8);
        end
        if (!corrupt) begin
            hide(ext_len, 32);
            for (longint unsigned i = 0; i < ext_len && img_q.size() < cap; i++)
                hide($urandom, 8);
            if (img_q.size() < cap) begin
                hide(pay_len, 32);
                for (longint unsigned i = 0; i < pay_len && img_q.size() < cap; i++)
                    hide($urandom, 8);
            end
        end
        while (img_q.size() > cap)
            void'(img_q.pop_back());
        repeat (tail) img_q.push_back(8'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // image channel driver
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic fs);
        lse_result_t r;
        if (src_idle && $urandom_range(0, 5) == 0) begin
            image.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        image.valid <= 1'b1;
        image.image_byte <= b;
        image.frame_start <= fs;
        @(posedge clk);
        while (!image.ready)
            @(posedge clk);
        beats_sent++;
        if (decode_beat(b, fs, r)) begin
            // error beat is fixed: zero byte, error section, no last flag
            if (typed_error) begin
                r.out_byte = 8'h00;
                r.section = SEC_ERROR;
                r.section_last = 1'b0;
            end
            hidden_due.push_back(r);
        end
    endtask

    task automatic play(input int from, input int upto, input bit lead_fs);
        for (int i = from; i < upto; i++)
            send_beat(img_q[i], lead_fs && i == 0);
    endtask

    // stop the stream and let every pending beat drain
    task automatic settle();
        image.valid <= 1'b0;
        while (hidden_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        reg_writes++;
        case (idx)
            REG_HEADER_SKIP:  skip_len = val[SKIP_W-1:0];
            REG_MAGIC_VALUE:  magic_word = val;
            REG_MAGIC_LENGTH: magic_len = val[MAGIC_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [SKIP_W-1:0] skip, input logic [MAGIC_W-1:0] magic,
                             input logic [MAGIC_LEN_W-1:0] len);
        settle();
        write_reg(REG_HEADER_SKIP, 64'(skip));
        write_reg(REG_MAGIC_VALUE, magic);
        write_reg(REG_MAGIC_LENGTH, 64'(len));
        cfg_we <= 1'b0;
    endtask

    function automatic void add_case(input bit load, input logic [SKIP_W-1:0] skip,
                                     input logic [MAGIC_W-1:0] magic,
                                     input logic [MAGIC_LEN_W-1:0] mlen, input bit bad,
                                     input logic [WORD_W-1:0] ext_len,
                                     input logic [WORD_W-1:0] pay_len,
                                     input int unsigned cut, input int unsigned tail,
                                     input int unsigned split,
                                     input logic [SKIP_W-1:0] new_skip, input bit lead_fs);
        file_case_t c;
        c.load = load;
        c.skip = skip;
        c.magic = magic;
        c.mlen = mlen;
        c.bad = bad;
        c.ext_len = ext_len;
        c.pay_len = pay_len;
        c.cut = cut;
        c.tail = tail;
        c.split = split;
        c.new_skip = new_skip;
        c.lead_fs = lead_fs;
        file_plan.push_back(c);
    endfunction

    // ------------------------------------------------------------------------
    // hidden channel: random stall bursts on ready
    // ------------------------------------------------------------------------
    initial begin
        hidden.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (sink_stall && !quiet && $urandom_range(0, 3) == 0) begin
                hidden.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            hidden.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // check every accepted hidden beat against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && hidden.valid && hidden.ready) begin
            hidden_seen++;
            if (hidden_due.size() == 0) begin
                $error("hidden beat with nothing expected: out_byte %02h section %0d last %0b",
                       hidden.out_byte, hidden.section, hidden.section_last);
                failures++;
            end else begin
                want_r = hidden_due.pop_front();
                if (hidden.out_byte !== want_r.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want_r.out_byte, hidden.out_byte);
                    failures++;
                end
                if (hidden.section !== want_r.section) begin
                    $error("section: expected %0d, got %0d", want_r.section, hidden.section);
                    failures++;
                end
                if (hidden.section_last !== want_r.section_last) begin
                    $error("section_last: expected %0b, got %0b",
                           want_r.section_last, hidden.section_last);
                    failures++;
                end
            end
        end
    end

    // run limit
    initial begin
        #(40_000_000);
        $error("run did not finish in time, %0d hidden beats outstanding", hidden_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int kind;
        int unsigned n;
        int unsigned tail;
        int rand_beats;
        file_case_t c;

        image.valid <= 1'b0;
        image.image_byte <= '0;
        image.frame_start <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_HEADER_SKIP;
        cfg_data <= '0;
        rst_n <= 1'b0;
        skip_len = HEADER_SKIP_RST;
        magic_word = MAGIC_VALUE_RST;
        magic_len = MAGIC_LENGTH_RST;
        restart_parse();

        // directed table
        //       load skip       magic                    mlen  bad ext_len       pay_len
        //                                                            cut tail split new_skip fs
        // reset registers, stream with no frame_start
        add_case(0, 16'd54,    64'h0,                   4'd2,  0, 32'd1,        32'd2,
                 0, 4, 0, 16'd0, 0);
        // no header, longest all-ones magic, empty extension, junk after end
        add_case(1, 16'd0,     64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  0, 32'd0,        32'd1,
                 0, 6, 0, 16'd0, 1);
        // magic length 0 reads as 1, empty payload
        add_case(1, 16'd0,     64'h0,                   4'd0,  0, 32'd2,        32'd0,
                 0, 6, 0, 16'd0, 1);
        // magic mismatch: one error beat, rest of file ignored
        add_case(1, 16'd3,     64'hA5,                  4'd1,  1, 32'd1,        32'd1,
                 0, 20, 0, 16'd0, 1);
        // magic length above the maximum is clamped
        add_case(1, 16'd5,     64'h0123_4567_89AB_CDEF, 4'd15, 0, 32'd3,        32'd3,
                 0, 4, 0, 16'd0, 1);
        add_case(1, 16'd5,     64'h0123_4567_89AB_CDEF, 4'd15, 1, 32'd3,        32'd3,
                 0, 24, 0, 16'd0, 1);
        // both sections empty
        add_case(1, 16'd0,     64'hBEEF,                4'd2,  0, 32'd0,        32'd0,
                 0, 12, 0, 16'd0, 1);
        // full-scale lengths, file cut short and restarted by the next one
        add_case(1, 16'd1,     64'h42,                  4'd1,  0, 32'hFFFF_FFFF, 32'd0,
                 80, 0, 0, 16'd0, 1);
        add_case(1, 16'd2,     64'h42,                  4'd1,  0, 32'd1,        32'h8000_0001,
                 90, 0, 0, 16'd0, 1);
        // largest header_skip, file ends while still inside the header
        add_case(1, 16'd65535, 64'h7E,                  4'd1,  0, 32'd1,        32'd1,
                 40, 2, 0, 16'd0, 1);
        // header_skip rewritten while the file is paused in the header
        add_case(1, 16'd40,    64'h5A,                  4'd1,  0, 32'd1,        32'd2,
                 0, 0, 10, 16'd12, 1);
        add_case(1, 16'd4,     64'h00FF,                4'd2,  0, 32'd2,        32'd2,
                 0, 3, 0, 16'd0, 1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (file_plan[i]) begin
            c = file_plan[i];
            if (c.load)
                configure(c.skip, c.magic, c.mlen);
            typed_error = c.bad;
            build_file((c.split != 0) ? c.new_skip : c.skip, magic_bytes(c.mlen), c.magic,
                       c.bad, c.ext_len, c.pay_len, c.cut, c.tail);
            if (c.split != 0) begin
                play(0, c.split, c.lead_fs);
                settle();
                write_reg(REG_HEADER_SKIP, 64'(c.new_skip));
                cfg_we <= 1'b0;
                play(c.split, img_q.size(), c.lead_fs);
            end else begin
                play(0, img_q.size(), c.lead_fs);
            end
            file_no++;
        end
        typed_error = 0;

        // random files: mostly well formed, some mangled, some plain noise
        rand_beats = 0;
        while (rand_beats < RAND_BEATS) begin
            quiet = (rand_beats >= RAND_BEATS - QUIET_BEATS);
            src_idle = !quiet && ($urandom_range(0, 2) != 0);
            sink_stall = !quiet && ($urandom_range(0, 2) != 0);
            if (file_no % 4 == 0) begin
                case ($urandom_range(0, 9))
                    0: n = 0;
                    1: n = HEADER_SKIP_RST;
                    default: n = $urandom_range(1, 8);
                endcase
                configure(16'(n), {$urandom, $urandom}, 4'($urandom));
            end
            kind = $urandom_range(0, 99);
            if (kind >= 92) begin
                n = $urandom_range(1, 40);
                repeat (n) send_beat(8'($urandom), $urandom_range(0, 7) == 0);
                rand_beats += n;
            end else begin
                tail = $urandom_range(0, 6);
                build_file(skip_len, magic_bytes(magic_len), magic_word,
                           kind >= 70 && kind < 82,
                           $urandom_range(0, 4), $urandom_range(0, 8),
                           (kind >= 82) ? $urandom_range(1, 200) : 0, tail);
                play(0, img_q.size(), $urandom_range(0, 9) != 0);
                rand_beats += img_q.size() - tail;
            end
            file_no++;
        end

        settle();
        if (hidden_due.size() != 0) begin
            $error("%0d expected hidden beats never arrived", hidden_due.size());
            failures++;
        end
        $display("Covered %0d files and noise bursts, %0d image beats, %0d hidden beats, %0d reg writes",
                 file_no, beats_sent, hidden_seen, reg_writes);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/lse_pkg.sv
rtl/lse_image_if.sv
rtl/lse_hidden_if.sv
rtl/lse_parser.sv
rtl/lsb_stego_extractor.sv
test/lsb_stego_extractor_test.sv
